### rtl/core/rcos_pkg.sv
// Shared types and constants for the rectangle clip / outline splitter.
// No dependencies; every other file in rtl/core but rcos_cmd_if imports this package.
package rcos_pkg;

    localparam int IMG_MAX     = 16384;
    localparam int LIM_W       = 15;
    localparam int POS_W       = 14;
    localparam int NPIECE      = 4;
    localparam int SPLIT_MIN   = 2;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;
    localparam logic [LIM_W-1:0]     IMG_RESET        = 15'd1024;

    // piece order inside a split outline
    localparam int PIECE_TOP    = 0;
    localparam int PIECE_RIGHT  = 1;
    localparam int PIECE_BOTTOM = 2;
    localparam int PIECE_LEFT   = 3;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // clipped piece: half-open span [x0,x1) x [y0,y1), already clamped
    typedef struct packed {
        logic [LIM_W-1:0] x0;
        logic [LIM_W-1:0] y0;
        logic [LIM_W-1:0] x1;
        logic [LIM_W-1:0] y1;
    } t_piece;

    typedef t_piece [NPIECE-1:0] t_piece_set;
    typedef logic [NPIECE-1:0]   t_piece_mask;

    localparam int PSET_W = $bits(t_piece_set);

    // image bounds after limiting to IMG_MAX
    typedef struct packed {
        logic [LIM_W-1:0] img_w;
        logic [LIM_W-1:0] img_h;
    } t_bounds;

    // handshake between front/back and the queue
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### rtl/core/rcos_cmd_if.sv
// Command channel: valid/ready handshake with one rectangle command word.
// Depends on nothing; widths set by interface parameters.
interface rcos_cmd_if #(
    parameter int COORD_BITS = 16,
    parameter int PIXEL_BITS = 32
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] rect_left;
    logic signed [COORD_BITS-1:0] rect_top;
    logic signed [COORD_BITS-1:0] rect_width;
    logic signed [COORD_BITS-1:0] rect_height;
    logic                         solid;
    logic [PIXEL_BITS-1:0]        ink_word;

    modport source (output valid, rect_left, rect_top, rect_width, rect_height, solid,
                    ink_word, input ready);
    modport sink   (input valid, rect_left, rect_top, rect_width, rect_height, solid,
                    ink_word, output ready);
endinterface

### rtl/core/rcos_rect_if.sv
// Result channel: valid/ready handshake with one clipped rectangle word.
// Depends on rcos_pkg for the fixed coordinate widths.
interface rcos_rect_if #(
    parameter int PIXEL_BITS = 32
) ();
    import rcos_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [POS_W-1:0]      clip_left;
    logic [POS_W-1:0]      clip_top;
    logic [LIM_W-1:0]      clip_width;
    logic [LIM_W-1:0]      clip_height;
    logic [PIXEL_BITS-1:0] paint_value;
    logic                  final_piece;

    modport source (output valid, clip_left, clip_top, clip_width, clip_height,
                    paint_value, final_piece, input ready);
    modport sink   (input valid, clip_left, clip_top, clip_width, clip_height,
                    paint_value, final_piece, output ready);
endinterface

### rtl/core/rcos_front.sv
// Front end: accepts commands, forms edges, classifies solid/outline,
// clips all pieces and pushes non-empty commands to the queue. Uses rcos_pkg.
module rcos_front #(
    parameter int COORD_BITS = 16,
    parameter int PIXEL_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rcos_cmd_if.sink             i_cmd,
    input  rcos_pkg::t_bounds    i_bounds,
    input  rcos_pkg::t_q_status  i_qstat,
    output logic                 o_push,
    output logic [PIXEL_BITS+rcos_pkg::NPIECE+rcos_pkg::PSET_W-1:0] o_data
);
    import rcos_pkg::*;

    // edge width: l+w-1 needs two bits above the command width
    localparam int EW = COORD_BITS + 2;
    // compare width: wide enough to hold IMG_MAX as a signed value
    localparam int CW = (EW > LIM_W + 2) ? EW : LIM_W + 2;

    // stage A: raw edges of the command
    logic                  r_a_valid;
    logic signed [EW-1:0]  r_l, r_t, r_r, r_b, r_rm1, r_bm1, r_lp1, r_tp1;
    logic                  r_split;
    logic [PIXEL_BITS-1:0] r_ink;

    logic signed [EW-1:0]  lx, tx, wx, hx;
    logic                  advance;
    logic                  accept;

    t_piece_set            pieces;
    t_piece_mask           mask;
    logic [LIM_W-1:0]      xl_lo, xr_lo, xr_hi, xl1_hi;
    logic [LIM_W-1:0]      yt_lo, yb_lo, yb_hi, yt1_hi;

    // clamp a start edge into [0, IMG_MAX]
    function automatic logic [LIM_W-1:0] clamp_lo(input logic signed [EW-1:0] v);
        logic signed [CW-1:0] s;
        logic [LIM_W-1:0]     res;
        s = v;
        if (s < 0) begin
            res = '0;
        end else if (s > CW'(IMG_MAX)) begin
            res = LIM_W'(IMG_MAX);
        end else begin
            res = s[LIM_W-1:0];
        end
        return res;
    endfunction

    // clamp an end edge into [0, lim]
    function automatic logic [LIM_W-1:0] clamp_hi(input logic signed [EW-1:0] v,
                                                  input logic [LIM_W-1:0] lim);
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] ls;
        logic [LIM_W-1:0]     res;
        s  = v;
        ls = {{(CW-LIM_W){1'b0}}, lim};
        if (s < 0) begin
            res = '0;
        end else if (s > ls) begin
            res = lim;
        end else begin
            res = s[LIM_W-1:0];
        end
        return res;
    endfunction

    assign lx = i_cmd.rect_left;
    assign tx = i_cmd.rect_top;
    assign wx = i_cmd.rect_width;
    assign hx = i_cmd.rect_height;

    assign accept      = i_cmd.valid && i_cmd.ready;
    assign advance     = (mask == '0) || !i_qstat.full;
    assign i_cmd.ready = !r_a_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_a_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_l     <= lx;
            r_t     <= tx;
            r_r     <= lx + wx;
            r_b     <= tx + hx;
            r_rm1   <= lx + wx - EW'(1);
            r_bm1   <= tx + hx - EW'(1);
            r_lp1   <= lx + EW'(1);
            r_tp1   <= tx + EW'(1);
            r_split <= !i_cmd.solid && (i_cmd.rect_width > SPLIT_MIN)
                       && (i_cmd.rect_height > SPLIT_MIN);
            r_ink   <= i_cmd.ink_word;
        end
    end

    // stage B: clamp the few distinct edges, then assemble pieces
    always_comb begin
        xl_lo  = clamp_lo(r_l);
        xr_lo  = clamp_lo(r_rm1);
        xr_hi  = clamp_hi(r_r, i_bounds.img_w);
        xl1_hi = clamp_hi(r_lp1, i_bounds.img_w);
        yt_lo  = clamp_lo(r_t);
        yb_lo  = clamp_lo(r_bm1);
        yb_hi  = clamp_hi(r_b, i_bounds.img_h);
        yt1_hi = clamp_hi(r_tp1, i_bounds.img_h);

        pieces = '0;
        if (r_split) begin
            pieces[PIECE_TOP]    = '{x0: xl_lo, y0: yt_lo, x1: xr_hi,  y1: yt1_hi};
            pieces[PIECE_RIGHT]  = '{x0: xr_lo, y0: yt_lo, x1: xr_hi,  y1: yb_hi};
            pieces[PIECE_BOTTOM] = '{x0: xl_lo, y0: yb_lo, x1: xr_hi,  y1: yb_hi};
            pieces[PIECE_LEFT]   = '{x0: xl_lo, y0: yt_lo, x1: xl1_hi, y1: yb_hi};
        end else begin
            pieces[PIECE_TOP]    = '{x0: xl_lo, y0: yt_lo, x1: xr_hi,  y1: yb_hi};
        end

        mask = '0;
        for (int k = 0; k < NPIECE; k++) begin
            mask[k] = r_a_valid && (r_split || k == PIECE_TOP)
                      && (pieces[k].x1 > pieces[k].x0) && (pieces[k].y1 > pieces[k].y0);
        end
    end

    // drop commands with nothing to paint
    assign o_push = r_a_valid && (mask != '0) && !i_qstat.full;
    assign o_data = {r_ink, mask, pieces};

endmodule

### rtl/core/rcos_queue.sv
// Small register queue between front and back; holds whole clipped commands.
// Uses rcos_pkg for depth and status struct.
module rcos_queue #(
    parameter int W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [W-1:0]         i_data,
    input  logic                 i_pop,
    output logic [W-1:0]         o_head,
    output rcos_pkg::t_q_status  o_stat
);
    import rcos_pkg::*;

    logic [W-1:0]      r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue popped while empty");

endmodule

### rtl/core/rcos_back.sv
// Back end: walks the surviving pieces of the head command into the output register, one
// per cycle while the result channel takes them, and marks the last one. Uses rcos_pkg.
module rcos_back #(
    parameter int PIXEL_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [PIXEL_BITS+rcos_pkg::NPIECE+rcos_pkg::PSET_W-1:0] i_head,
    input  rcos_pkg::t_q_status  i_qstat,
    output logic                 o_pop,
    rcos_rect_if.source          o_rect
);
    import rcos_pkg::*;

    t_piece_set            head_set;
    t_piece_mask           head_mask;
    logic [PIXEL_BITS-1:0] head_ink;

    logic                  r_have;
    t_piece_mask           r_rem;
    t_piece_mask           rem;
    t_piece_mask           new_rem;
    logic [QPTR_W-1:0]     idx;
    logic                  load_ok;
    logic                  go;
    logic                  last;
    t_piece                pc;

    logic                  r_ovalid;
    logic [POS_W-1:0]      r_left, r_top;
    logic [LIM_W-1:0]      r_width, r_height;
    logic [PIXEL_BITS-1:0] r_paint;
    logic                  r_final;

    assign head_set  = t_piece_set'(i_head[PSET_W-1:0]);
    assign head_mask = i_head[PSET_W +: NPIECE];
    assign head_ink  = i_head[PSET_W+NPIECE +: PIXEL_BITS];

    // lowest remaining piece goes next
    always_comb begin
        rem = r_have ? r_rem : head_mask;
        idx = '0;
        for (int k = NPIECE - 1; k >= 0; k--) begin
            if (rem[k]) begin
                idx = QPTR_W'(k);
            end
        end
        new_rem = rem;
        new_rem[idx] = 1'b0;
        last = (new_rem == '0);
        pc   = head_set[idx];
    end

    assign load_ok = !r_ovalid || o_rect.ready;
    assign go      = !i_qstat.empty && load_ok;
    assign o_pop   = go && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_rem    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (go) begin
                r_have <= !last;
                r_rem  <= new_rem;
            end
            if (load_ok) begin
                r_ovalid <= go;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_left   <= pc.x0[POS_W-1:0];
            r_top    <= pc.y0[POS_W-1:0];
            r_width  <= pc.x1 - pc.x0;
            r_height <= pc.y1 - pc.y0;
            r_paint  <= head_ink;
            r_final  <= last;
        end
    end

    assign o_rect.valid       = r_ovalid;
    assign o_rect.clip_left   = r_left;
    assign o_rect.clip_top    = r_top;
    assign o_rect.clip_width  = r_width;
    assign o_rect.clip_height = r_height;
    assign o_rect.paint_value = r_paint;
    assign o_rect.final_piece = r_final;

    a_head_has_piece: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |-> (rem != '0))
        else $error("queued command carries no piece");

    a_mid_cmd_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> !i_qstat.empty)
        else $error("head command lost while pieces remain");

endmodule

### rtl/core/rect_clip_outline_splitter.sv
// Top level of the rectangle clip / outline splitter: image bound registers,
// front end, command queue and back end. Uses rcos_pkg and both channel interfaces.
//
//  channel   dir  handshake             word
//  i_cmd     in   valid/ready           left, top, width, height, solid, ink
//  o_rect    out  valid/ready           clipped left, top, width, height, ink, last flag
//  i_cfg_*   in   write enable only     index 0 image width, 1 image height
//
// A command's edge adders are registered in stage A when it is taken, with the clamp compares
// in front of the queue; its rectangles then pass through the queue into the back end's
// output register. The back end sends one rectangle per cycle while the result channel takes
// them, so a command yields 1 to 4 rectangles, one per surviving piece; commands that clip
// to nothing yield none. The front takes a command every cycle while the four-entry queue has room.
// Reset is synchronous: clears handshake state, sets both bounds to 1024, no sweep.
module rect_clip_outline_splitter #(
    parameter int COORD_BITS = 16,
    parameter int PIXEL_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    rcos_cmd_if.sink                            i_cmd,
    rcos_rect_if.source                         o_rect,
    input  logic                                i_cfg_we,
    input  logic [rcos_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rcos_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rcos_pkg::*;

    localparam int QW = PIXEL_BITS + NPIECE + PSET_W;

    t_bounds          r_bounds;
    logic [LIM_W-1:0] cfg_lim;

    logic             push;
    logic             pop;
    logic [QW-1:0]    q_in;
    logic [QW-1:0]    q_head;
    t_q_status        qstat;

    // hold oversized bounds at the image maximum
    assign cfg_lim = (i_cfg_data > CFG_DATA_W'(IMG_MAX)) ? LIM_W'(IMG_MAX) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds.img_w <= IMG_RESET;
            r_bounds.img_h <= IMG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_bounds.img_w <= cfg_lim;
                CFG_IMAGE_HEIGHT: r_bounds.img_h <= cfg_lim;
                default:          r_bounds <= r_bounds;
            endcase
        end
    end

    rcos_front #(
        .COORD_BITS (COORD_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_bounds (r_bounds),
        .i_qstat  (qstat),
        .o_push   (push),
        .o_data   (q_in)
    );

    rcos_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_stat  (qstat)
    );

    rcos_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_rect  (o_rect)
    );

endmodule
